[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this project.
// Needs nothing else; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released.
`define FST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, including those in reset.
`define FST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fst_pkg.sv]
// Shared types and constants for the flow statistics table.
// Used by fst_mem, fst_ctrl, flow_stats_table and fst_checker.
package fst_pkg;

  localparam int unsigned MAX_FLOWS_DEF  = 64;
  localparam int unsigned FLOW_LIMIT_W   = 7;
  localparam logic [FLOW_LIMIT_W-1:0] FLOW_LIMIT_RST = 7'd64;
  localparam int unsigned RTT_SHIFT      = 3;
  localparam int unsigned IN_DATA_W      = 224;
  localparam int unsigned OUT_DATA_W     = 224;

  // Operation code carried on in_tuser.
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_DUMP    = 1'b1;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } flow_key_t;

  typedef struct packed {
    logic [28:0] srtt;
    logic [28:0] rttvar;
    logic [31:0] cwnd;
    logic [31:0] retrans;
  } flow_stats_t;

  typedef struct packed {
    flow_key_t   key;
    flow_stats_t stats;
  } flow_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_APPEND,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } fst_state_t;

endpackage

[rtl/fst_mem.sv]
// Flow entry memory: one write port and one read port with registered data.
// Depends on fst_pkg for the entry type.
module fst_mem #(
  parameter int unsigned DEPTH = fst_pkg::MAX_FLOWS_DEF,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  fst_pkg::flow_entry_t wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output fst_pkg::flow_entry_t rd_data
);

  fst_pkg::flow_entry_t mem [DEPTH];
  fst_pkg::flow_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/fst_ctrl.sv]
// Sequencer for the flow table: walks stored entries through one key
// comparator for lookups, appends new flows and streams dumps. Uses fst_pkg.
module fst_ctrl #(
  parameter int unsigned MAX_FLOWS = fst_pkg::MAX_FLOWS_DEF,
  parameter int unsigned IDX_W     = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1,
  parameter int unsigned CNT_W     = $clog2(MAX_FLOWS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fst_pkg::FLOW_LIMIT_W-1:0]    cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_op,
  input  fst_pkg::flow_key_t                  in_key,
  input  fst_pkg::flow_stats_t                in_stats,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fst_pkg::flow_entry_t                out_entry,
  output logic                                out_last,
  output logic                                mem_wr_en,
  output logic [IDX_W-1:0]                    mem_wr_addr,
  output fst_pkg::flow_entry_t                mem_wr_data,
  output logic                                mem_rd_en,
  output logic [IDX_W-1:0]                    mem_rd_addr,
  input  fst_pkg::flow_entry_t                mem_rd_data
);

  localparam int unsigned LIM_W = fst_pkg::FLOW_LIMIT_W;

  fst_pkg::fst_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [LIM_W-1:0]             limit_r;
  fst_pkg::flow_key_t           key_r;
  fst_pkg::flow_stats_t         stats_r;
  logic                         out_valid_r, out_valid_nxt;
  fst_pkg::flow_entry_t         out_entry_r;
  logic                         out_last_r;

  logic                         in_fire;
  logic                         load_out;
  logic                         at_last;
  logic                         key_hit;
  logic [CNT_W-1:0]             idx_inc;
  logic [LIM_W-1:0]             limit_eff;

  assign in_fire   = in_tvalid && in_tready;
  assign idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
  assign at_last   = (idx_inc == cnt_r);
  assign key_hit   = (mem_rd_data.key == key_r);
  assign limit_eff = (limit_r > LIM_W'(MAX_FLOWS)) ? LIM_W'(MAX_FLOWS) : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fst_pkg::ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      limit_r     <= fst_pkg::FLOW_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_key;
      stats_r <= in_stats;
    end
    if (load_out) begin
      out_entry_r <= mem_rd_data;
      out_last_r  <= at_last;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    in_tready   = 1'b0;
    load_out    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r;

    case (state_r)
      fst_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt = '0;
          if (in_op == fst_pkg::OP_DUMP) begin
            // An empty table answers a dump with nothing.
            if (cnt_r != '0) begin
              state_nxt = fst_pkg::ST_DUMP_RD;
            end
          end else if (cnt_r == '0) begin
            state_nxt = fst_pkg::ST_APPEND;
          end else begin
            state_nxt = fst_pkg::ST_RD;
          end
        end
      end
      fst_pkg::ST_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = fst_pkg::ST_CMP;
      end
      fst_pkg::ST_CMP: begin
        if (key_hit) begin
          mem_wr_en = 1'b1;
          state_nxt = fst_pkg::ST_IDLE;
        end else if (at_last) begin
          state_nxt = fst_pkg::ST_APPEND;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = fst_pkg::ST_RD;
        end
      end
      fst_pkg::ST_APPEND: begin
        // The count stays below the limit, and so below the depth, here.
        if (LIM_W'(cnt_r) < limit_eff) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        state_nxt = fst_pkg::ST_IDLE;
      end
      fst_pkg::ST_DUMP_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = fst_pkg::ST_DUMP_OUT;
      end
      fst_pkg::ST_DUMP_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          if (at_last) begin
            state_nxt = fst_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = fst_pkg::ST_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = fst_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || load_out;
  end

  assign mem_wr_data.key   = key_r;
  assign mem_wr_data.stats = stats_r;
  assign out_valid         = out_valid_r;
  assign out_entry         = out_entry_r;
  assign out_last          = out_last_r;

endmodule

[rtl/flow_stats_table.sv]
// Flow statistics table: lookup, update, append and dump of TCP flows.
// Observe word: each stored entry is read and then compared in turn; a miss goes on to append.
// Dump word: each entry is read and then loaded as one result, held while the output stalls.
// Both walk the entries through the single read port of the entry memory; a new word waits for idle.
// Reset is synchronous, active low: entry count to zero, flow limit to 64, output empty.
// The entry memory is not cleared; only entries below the count are ever read.
module flow_stats_table #(
  parameter int unsigned MAX_FLOWS = fst_pkg::MAX_FLOWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [fst_pkg::FLOW_LIMIT_W-1:0]      cfg_wr_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // src_addr, dst_addr, src_port, dst_port, srtt_raw, rttvar_raw, cwnd_in, retrans_in
  input  logic [fst_pkg::IN_DATA_W-1:0]         in_tdata,
  // operation
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_src_addr, out_dst_addr, out_src_port, out_dst_port, out_srtt, out_rttvar,
  // out_cwnd, out_retrans, zero fill
  output logic [fst_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast
);

  localparam int unsigned IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FLOWS + 1);

  fst_pkg::flow_key_t   in_key;
  fst_pkg::flow_stats_t in_stats;
  fst_pkg::flow_entry_t out_entry;
  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  fst_pkg::flow_entry_t mem_wr_data;
  logic                 mem_rd_en;
  logic [IDX_W-1:0]     mem_rd_addr;
  fst_pkg::flow_entry_t mem_rd_data;

  assign in_key.src_addr  = in_tdata[31:0];
  assign in_key.dst_addr  = in_tdata[63:32];
  assign in_key.src_port  = in_tdata[79:64];
  assign in_key.dst_port  = in_tdata[95:80];
  assign in_stats.srtt    = in_tdata[127:96+fst_pkg::RTT_SHIFT];
  assign in_stats.rttvar  = in_tdata[159:128+fst_pkg::RTT_SHIFT];
  assign in_stats.cwnd    = in_tdata[191:160];
  assign in_stats.retrans = in_tdata[223:192];

  fst_ctrl #(
    .MAX_FLOWS (MAX_FLOWS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tuser),
    .in_key      (in_key),
    .in_stats    (in_stats),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_entry   (out_entry),
    .out_last    (out_tlast),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fst_mem #(
    .DEPTH (MAX_FLOWS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_tdata = {6'd0,
                      out_entry.stats.retrans,
                      out_entry.stats.cwnd,
                      out_entry.stats.rttvar,
                      out_entry.stats.srtt,
                      out_entry.key.dst_port,
                      out_entry.key.src_port,
                      out_entry.key.dst_addr,
                      out_entry.key.src_addr};

endmodule

[rtl/fst_checker.sv]
// Port-level checks for flow_stats_table, attached by the bind below.
// Depends on assert_macros.svh and fst_pkg.
`include "assert_macros.svh"

module fst_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fst_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  // A stalled result word keeps its place on the output.
  `FST_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out word dropped while stalled")
  `FST_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "out word changed while stalled")
  // Reset leaves the block empty and ready for a word.
  `FST_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_tvalid && in_tready, "block not idle after reset")
  // An observe word always takes the search or append sequence, so the input closes.
  `FST_ASSERT(a_observe_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser == fst_pkg::OP_OBSERVE) |=> !in_tready, "input open right after an observe word")

endmodule

bind flow_stats_table fst_checker u_fst_checker (.*);
